/* rtl/zph_pkg.sv */
// Package for the Zobrist position hash unit: item types, codes and constants.
// Depends on nothing; the datapath, controller, top level and testbench take names from here.
`timescale 1ns / 1ps

package zph_pkg;

   localparam int SQUARE_COUNT_DEF = 64;
   localparam int PIECE_TYPES      = 7;
   localparam int CASTLE_KEYS      = 16;

   localparam logic [63:0] SEED_TWICE = 64'h3c6ef372fe94f82a;
   localparam logic [63:0] MIX_MUL_A  = 64'hbf58476d1ce4e5b9;
   localparam logic [63:0] MIX_MUL_B  = 64'h94d049bb133111eb;
   localparam int SHIFT_PRE  = 30;
   localparam int SHIFT_MID  = 27;
   localparam int SHIFT_POST = 31;

   typedef enum logic [1:0] {
      FUNC_PIECE  = 2'd0,
      FUNC_CASTLE = 2'd1,
      FUNC_EP     = 2'd2,
      FUNC_SIDE   = 2'd3
   } func_type;

   typedef struct packed {
      logic [1:0] func;
      logic [2:0] piece_type;
      logic       piece_color;
      logic [5:0] square;
      logic [3:0] castle_mask;
      logic       present;
      logic       last;
   } item_type;

   typedef enum logic [2:0] {
      DP_HOLD,
      DP_LOAD,
      DP_MUL_LO,
      DP_MUL_HI_A,
      DP_MUL_HI_B,
      DP_FOLD
   } op_type;

   typedef struct packed {
      op_type op;
      logic   round;
      logic   commit;
   } cmd_type;

   typedef struct packed {
      logic last;
      logic rsp_busy;
   } status_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_MUL_LO,
      ST_MUL_HI_A,
      ST_MUL_HI_B,
      ST_FOLD
   } state_type;

endpackage

/* rtl/zph_if.sv */
// Handshake channels of the Zobrist position hash unit: term input and hash result.
// Depends on nothing; payload widths follow the fields of one item.
`timescale 1ns / 1ps

interface zph_req_if;
   logic       valid;
   logic       ready;
   logic [1:0] func;
   logic [2:0] piece_type;
   logic       piece_color;
   logic [5:0] square;
   logic [3:0] castle_mask;
   logic       present;
   logic       last;

   modport source (output valid, func, piece_type, piece_color, square, castle_mask,
                   present, last, input ready);
   modport sink (input valid, func, piece_type, piece_color, square, castle_mask,
                 present, last, output ready);
endinterface

interface zph_rsp_if;
   logic        valid;
   logic        ready;
   logic [63:0] hash;

   modport source (output valid, hash, input ready);
   modport sink (input valid, hash, output ready);
endinterface

/* rtl/zph_dp.sv */
// Datapath of the Zobrist position hash unit: key index, splitmix64 mixer on one
// shared 32x32 multiplier, hash accumulator and result register. Uses zph_pkg.
`timescale 1ns / 1ps

module zph_dp #(
   parameter int SQUARE_COUNT = zph_pkg::SQUARE_COUNT_DEF
) (
   input  logic               clock,
   input  logic               reset,
   input  zph_pkg::cmd_type    cmd,
   input  zph_pkg::item_type   item,
   input  logic               rsp_ready,
   output zph_pkg::status_type status,
   output logic               rsp_valid,
   output logic [63:0]        rsp_hash
);

   localparam int CASTLE_BASE = 2 * zph_pkg::PIECE_TYPES * SQUARE_COUNT;
   localparam int EP_BASE     = CASTLE_BASE + zph_pkg::CASTLE_KEYS;
   localparam int SIDE_INDEX  = EP_BASE + SQUARE_COUNT;
   localparam int IDX_W       = $clog2(SIDE_INDEX + 1);

   logic [63:0] x_ff, x_in;
   logic [63:0] y_ff, y_in;
   logic [63:0] prod_ff;
   logic [63:0] acc_ff, acc_in;
   logic [63:0] hash_ff, hash_in;
   logic        valid_ff, valid_in;
   logic        contrib_ff, contrib_in;
   logic        last_ff, last_in;

   logic [IDX_W-1:0] sq_ext;
   logic             sq_ok;
   logic             type_ok;
   logic [IDX_W-1:0] key_idx;
   logic [63:0]      seed_sum;
   logic [63:0]      mul_const;
   logic [31:0]      mul_a;
   logic [31:0]      mul_b;
   logic [63:0]      mul_out;
   logic [63:0]      folded;
   logic [63:0]      key;
   logic [63:0]      acc_next;

   always_comb begin
      sq_ext  = IDX_W'(item.square);
      sq_ok   = sq_ext < IDX_W'(SQUARE_COUNT);
      type_ok = item.piece_type < 3'(zph_pkg::PIECE_TYPES);
      unique case (zph_pkg::func_type'(item.func))
         zph_pkg::FUNC_PIECE: begin
            key_idx    = IDX_W'({item.piece_type, item.piece_color}) * IDX_W'(SQUARE_COUNT)
                         + sq_ext;
            contrib_in = item.present && type_ok && sq_ok;
         end
         zph_pkg::FUNC_CASTLE: begin
            key_idx    = IDX_W'(CASTLE_BASE) + IDX_W'(item.castle_mask);
            contrib_in = 1'b1;
         end
         zph_pkg::FUNC_EP: begin
            key_idx    = IDX_W'(EP_BASE) + sq_ext;
            contrib_in = item.present && sq_ok;
         end
         zph_pkg::FUNC_SIDE: begin
            key_idx    = IDX_W'(SIDE_INDEX);
            contrib_in = item.present;
         end
         default: begin
            key_idx    = '0;
            contrib_in = 1'b0;
         end
      endcase
      seed_sum = zph_pkg::SEED_TWICE + 64'(key_idx);
   end

   always_comb begin
      mul_const = cmd.round ? zph_pkg::MIX_MUL_B : zph_pkg::MIX_MUL_A;
      mul_a     = (cmd.op == zph_pkg::DP_MUL_HI_A) ? x_ff[63:32] : x_ff[31:0];
      mul_b     = (cmd.op == zph_pkg::DP_MUL_HI_B) ? mul_const[63:32] : mul_const[31:0];
      mul_out   = 64'(mul_a) * 64'(mul_b);
      folded    = {y_ff[63:32] + prod_ff[31:0], y_ff[31:0]};
      key       = folded ^ (folded >> zph_pkg::SHIFT_POST);
      acc_next  = acc_ff ^ (contrib_ff ? key : 64'd0);
   end

   always_comb begin
      x_in     = x_ff;
      y_in     = y_ff;
      acc_in   = acc_ff;
      hash_in  = hash_ff;
      last_in  = last_ff;
      valid_in = valid_ff && !rsp_ready;
      unique case (cmd.op)
         zph_pkg::DP_HOLD: begin
         end
         zph_pkg::DP_LOAD: begin
            x_in    = seed_sum ^ (seed_sum >> zph_pkg::SHIFT_PRE);
            last_in = item.last;
         end
         zph_pkg::DP_MUL_LO: begin
         end
         zph_pkg::DP_MUL_HI_A: begin
            y_in = prod_ff;
         end
         zph_pkg::DP_MUL_HI_B: begin
            y_in = {y_ff[63:32] + prod_ff[31:0], y_ff[31:0]};
         end
         zph_pkg::DP_FOLD: begin
            if (!cmd.round) begin
               x_in = folded ^ (folded >> zph_pkg::SHIFT_MID);
            end else if (cmd.commit) begin
               if (last_ff) begin
                  hash_in  = acc_next;
                  valid_in = 1'b1;
                  acc_in   = '0;
               end else begin
                  acc_in = acc_next;
               end
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      x_ff    <= x_in;
      y_ff    <= y_in;
      hash_ff <= hash_in;
      last_ff <= last_in;
      if (cmd.op != zph_pkg::DP_FOLD) begin
         prod_ff <= mul_out;
      end
      if (cmd.op == zph_pkg::DP_LOAD) begin
         contrib_ff <= contrib_in;
      end
      if (reset) begin
         acc_ff   <= '0;
         valid_ff <= 1'b0;
      end else begin
         acc_ff   <= acc_in;
         valid_ff <= valid_in;
      end
   end

   assign status.last     = last_ff;
   assign status.rsp_busy = valid_ff && !rsp_ready;
   assign rsp_valid       = valid_ff;
   assign rsp_hash        = hash_ff;

endmodule

/* rtl/zph_ctrl.sv */
// Controller of the Zobrist position hash unit: sequences the two multiply rounds
// of the key mixer and the accumulate step. Uses zph_pkg.
`timescale 1ns / 1ps

module zph_ctrl (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   input  zph_pkg::status_type status,
   output logic               req_ready,
   output zph_pkg::cmd_type    cmd
);

   zph_pkg::state_type state_ff, state_in;
   logic               round_ff, round_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= zph_pkg::ST_IDLE;
         round_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         round_ff <= round_in;
      end
   end

   always_comb begin
      state_in   = state_ff;
      round_in   = round_ff;
      req_ready  = 1'b0;
      cmd.op     = zph_pkg::DP_HOLD;
      cmd.round  = round_ff;
      cmd.commit = 1'b0;
      unique case (state_ff)
         zph_pkg::ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.op   = zph_pkg::DP_LOAD;
               round_in = 1'b0;
               state_in = zph_pkg::ST_MUL_LO;
            end
         end
         zph_pkg::ST_MUL_LO: begin
            cmd.op   = zph_pkg::DP_MUL_LO;
            state_in = zph_pkg::ST_MUL_HI_A;
         end
         zph_pkg::ST_MUL_HI_A: begin
            cmd.op   = zph_pkg::DP_MUL_HI_A;
            state_in = zph_pkg::ST_MUL_HI_B;
         end
         zph_pkg::ST_MUL_HI_B: begin
            cmd.op   = zph_pkg::DP_MUL_HI_B;
            state_in = zph_pkg::ST_FOLD;
         end
         zph_pkg::ST_FOLD: begin
            cmd.op = zph_pkg::DP_FOLD;
            if (!round_ff) begin
               round_in = 1'b1;
               state_in = zph_pkg::ST_MUL_LO;
            end else if (!(status.last && status.rsp_busy)) begin
               cmd.commit = 1'b1;
               state_in   = zph_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = zph_pkg::ST_IDLE;
         end
      endcase
   end

endmodule

/* rtl/zobrist_position_hash_unit.sv */
// Top level of the Zobrist position hash unit: joins controller and datapath.
// Depends on zph_pkg, zph_if.sv, zph_ctrl and zph_dp.
//
//   Channel   Direction   Payload                                         Handshake
//   req_ch    in          func piece_type piece_color square              valid/ready
//                         castle_mask present last
//   rsp_ch    out         hash (64 bits)                                  valid/ready
//
// A term is taken in, then passes through two mixer rounds of steps MUL_LO, MUL_HI_A,
// MUL_HI_B and FOLD, each round a 64-bit multiply from three products of one shared 32x32 multiplier.
// Synchronous active-high reset clears the accumulator, the controller and the result valid.
// The hash of a position waits in an output register; the next term is taken meanwhile.
// A last term whose hash is ready while the previous one still waits holds the controller.
`timescale 1ns / 1ps

module zobrist_position_hash_unit #(
   parameter int SQUARE_COUNT = zph_pkg::SQUARE_COUNT_DEF
) (
   input logic        clock,
   input logic        reset,
   zph_req_if.sink    req_ch,
   zph_rsp_if.source  rsp_ch
);

   zph_pkg::cmd_type    cmd;
   zph_pkg::status_type status;
   zph_pkg::item_type   item;

   assign item.func        = req_ch.func;
   assign item.piece_type  = req_ch.piece_type;
   assign item.piece_color = req_ch.piece_color;
   assign item.square      = req_ch.square;
   assign item.castle_mask = req_ch.castle_mask;
   assign item.present     = req_ch.present;
   assign item.last        = req_ch.last;

   zph_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_ch.valid),
      .status    (status),
      .req_ready (req_ch.ready),
      .cmd       (cmd)
   );

   zph_dp #(
      .SQUARE_COUNT (SQUARE_COUNT)
   ) u_dp (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .item      (item),
      .rsp_ready (rsp_ch.ready),
      .status    (status),
      .rsp_valid (rsp_ch.valid),
      .rsp_hash  (rsp_ch.hash)
   );

endmodule

/* rtl/zph_checker.sv */
// Port checker for the Zobrist position hash unit, attached by bind.
// Depends on zobrist_position_hash_unit and the channels of zph_if.sv.
`timescale 1ns / 1ps

module zph_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_ready,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [63:0] rsp_hash
);

   // A result holds until it is taken.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_hash))
      else $error("result dropped or changed while stalled");

   // Each term occupies the unit, so terms are never taken back to back.
   a_no_back_to_back: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("term taken in the cycle after another");

   // A result is written at the end of a term, while the input is closed.
   a_rsp_after_work: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(!req_ready))
      else $error("result appeared without a term being worked through");

   a_reset_clears: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid after reset");

endmodule

bind zobrist_position_hash_unit zph_checker u_zph_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_ch.valid),
   .req_ready (req_ch.ready),
   .rsp_valid (rsp_ch.valid),
   .rsp_ready (rsp_ch.ready),
   .rsp_hash  (rsp_ch.hash)
);

/* bench/zobrist_position_hash_unit_tb.sv */
// Self-checking testbench for zobrist_position_hash_unit: streams position terms and
// compares each emitted hash with a splitmix64 Zobrist predictor kept in a scoreboard.
// Depends on zph_pkg, the zph_req_if and zph_rsp_if channels, and the unit itself.
`timescale 1ns / 1ps

module zobrist_position_hash_unit_tb;

   localparam int SQUARES        = zph_pkg::SQUARE_COUNT_DEF;
   localparam int CASTLE_BASE    = 2 * zph_pkg::PIECE_TYPES * SQUARES;
   localparam int EP_BASE        = CASTLE_BASE + zph_pkg::CASTLE_KEYS;
   localparam int SIDE_INDEX     = EP_BASE + SQUARES;
   localparam int RANDOM_TERMS   = 700;
   localparam int LONG_HOLD      = 300;
   localparam int HOLD_AFTER     = 150;
   localparam int DRAIN_CYCLES   = 40;
   localparam int WATCHDOG_LIMIT = 4000;

   localparam logic [63:0] GOLDEN_RATIO = 64'h9e3779b97f4a7c15;
   localparam logic [63:0] FINAL_MUL_A  = 64'hbf58476d1ce4e5b9;
   localparam logic [63:0] FINAL_MUL_B  = 64'h94d049bb133111eb;

   class hash_scoreboard;
      logic [63:0] running_hash;
      logic [63:0] pending_hashes[$];
      int          mismatches;

      function new();
         running_hash = '0;
         mismatches   = 0;
      endfunction

      function logic [63:0] zobrist_key(input logic [63:0] index);
         logic [63:0] mixed;
         mixed = GOLDEN_RATIO + GOLDEN_RATIO + index;
         mixed = (mixed ^ (mixed >> 30)) * FINAL_MUL_A;
         mixed = (mixed ^ (mixed >> 27)) * FINAL_MUL_B;
         return mixed ^ (mixed >> 31);
      endfunction

      function void note_term(input zph_pkg::item_type term);
         logic [63:0] index;
         case (zph_pkg::func_type'(term.func))
            zph_pkg::FUNC_PIECE: begin
               if (term.present && term.piece_type < zph_pkg::PIECE_TYPES
                   && term.square < SQUARES) begin
                  index = ({61'd0, term.piece_type} * 64'd2 + 64'(term.piece_color))
                          * 64'(SQUARES) + 64'(term.square);
                  running_hash ^= zobrist_key(index);
               end
            end
            zph_pkg::FUNC_CASTLE: begin
               running_hash ^= zobrist_key(64'(CASTLE_BASE) + 64'(term.castle_mask));
            end
            zph_pkg::FUNC_EP: begin
               if (term.present && term.square < SQUARES)
                  running_hash ^= zobrist_key(64'(EP_BASE) + 64'(term.square));
            end
            default: begin
               if (term.present)
                  running_hash ^= zobrist_key(64'(SIDE_INDEX));
            end
         endcase
         if (term.last) begin
            pending_hashes.push_back(running_hash);
            running_hash = '0;
         end
      endfunction

      function void check_hash(input logic [63:0] hash);
         logic [63:0] expected;
         if (pending_hashes.size() == 0) begin
            if (mismatches < 10)
               $display("ERROR: hash %h arrived with no position pending", hash);
            mismatches++;
         end else begin
            expected = pending_hashes.pop_front();
            if (hash !== expected) begin
               if (mismatches < 10)
                  $display("ERROR: hash expected %h, got %h", expected, hash);
               mismatches++;
            end
         end
      endfunction

      function int pending();
         return pending_hashes.size();
      endfunction
   endclass

   logic clock;
   logic reset;

   zph_req_if req_ch ();
   zph_rsp_if rsp_ch ();

   zobrist_position_hash_unit #(
      .SQUARE_COUNT(SQUARES)
   ) dut (
      .clock (clock),
      .reset (reset),
      .req_ch(req_ch.sink),
      .rsp_ch(rsp_ch.source)
   );

   hash_scoreboard sb;
   int terms_seen;
   int idle_cycles;
   int burst_left;
   int terms_sent;

   always #1 clock = ~clock;

   initial begin
      clock              = 1'b0;
      reset              = 1'b1;
      req_ch.valid       = 1'b0;
      req_ch.func        = '0;
      req_ch.piece_type  = '0;
      req_ch.piece_color = 1'b0;
      req_ch.square      = '0;
      req_ch.castle_mask = '0;
      req_ch.present     = 1'b0;
      req_ch.last        = 1'b0;
      rsp_ch.ready       = 1'b0;
      sb                 = new();
      terms_seen         = 0;
      idle_cycles        = 0;
      burst_left         = 0;
      terms_sent         = 0;
   end

   always @(posedge clock) begin
      logic moved;
      if (!reset) begin
         moved = 1'b0;
         if (req_ch.valid && req_ch.ready) begin
            sb.note_term('{func: req_ch.func, piece_type: req_ch.piece_type,
                           piece_color: req_ch.piece_color, square: req_ch.square,
                           castle_mask: req_ch.castle_mask,
                           present: req_ch.present, last: req_ch.last});
            terms_seen++;
            moved = 1'b1;
         end
         if (rsp_ch.valid && rsp_ch.ready) begin
            sb.check_hash(rsp_ch.hash);
            moved = 1'b1;
         end
         idle_cycles = moved ? 0 : idle_cycles + 1;
         if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("Test completed with failures");
            $finish;
         end
      end
   end

   // The receiver holds off once for a long stretch so that the unit backs up into its input.
   initial begin
      bit held_long;
      int mode;
      int span;
      held_long = 1'b0;
      wait (!reset);
      forever begin
         if (!held_long && terms_seen >= HOLD_AFTER) begin
            rsp_ch.ready <= 1'b0;
            repeat (LONG_HOLD) @(posedge clock);
            held_long = 1'b1;
         end else begin
            mode = $urandom_range(0, 3);
            span = $urandom_range(1, 30);
            repeat (span) begin
               case (mode)
                  0: rsp_ch.ready <= 1'b1;
                  1: rsp_ch.ready <= 1'b0;
                  default: rsp_ch.ready <= 1'($urandom_range(0, 1));
               endcase
               @(posedge clock);
            end
         end
      end
   end

   function automatic zph_pkg::item_type make_term(input zph_pkg::func_type func,
                                                   input int ptype, input int color,
                                                   input int sq, input int rights,
                                                   input bit present, input bit last);
      zph_pkg::item_type term;
      term.func        = func;
      term.piece_type  = 3'(ptype);
      term.piece_color = 1'(color);
      term.square      = 6'(sq);
      term.castle_mask = 4'(rights);
      term.present     = present;
      term.last        = last;
      return term;
   endfunction

   function automatic zph_pkg::item_type random_term();
      zph_pkg::item_type term;
      term.func        = 2'($urandom_range(0, 3));
      term.piece_type  = 3'($urandom_range(0, 7));
      term.piece_color = 1'($urandom_range(0, 1));
      term.square      = 6'($urandom_range(0, 63));
      term.castle_mask = 4'($urandom_range(0, 15));
      term.present     = 1'($urandom_range(0, 1));
      term.last        = 1'b0;
      return term;
   endfunction

   task automatic drive_term(input zph_pkg::item_type term);
      int gap;
      if (burst_left == 0) begin
         gap        = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
         burst_left = $urandom_range(1, 24);
         if (gap > 0) begin
            req_ch.valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      burst_left--;
      req_ch.valid       <= 1'b1;
      req_ch.func        <= term.func;
      req_ch.piece_type  <= term.piece_type;
      req_ch.piece_color <= term.piece_color;
      req_ch.square      <= term.square;
      req_ch.castle_mask <= term.castle_mask;
      req_ch.present     <= term.present;
      req_ch.last        <= term.last;
      terms_sent++;
      do @(posedge clock); while (!req_ch.ready);
   endtask

   // A plausible position: pieces, mostly occupied, then castling, en passant and side.
   task automatic drive_position();
      zph_pkg::item_type term;
      int pieces;
      pieces = ($urandom_range(0, 7) == 0) ? $urandom_range(17, 32) : $urandom_range(1, 16);
      repeat (pieces) begin
         term            = random_term();
         term.func       = zph_pkg::FUNC_PIECE;
         term.piece_type = 3'(($urandom_range(0, 15) == 0) ? 7 : $urandom_range(0, 6));
         term.present    = ($urandom_range(0, 7) != 0);
         drive_term(term);
      end
      term      = random_term();
      term.func = zph_pkg::FUNC_CASTLE;
      drive_term(term);
      term      = random_term();
      term.func = zph_pkg::FUNC_EP;
      drive_term(term);
      term      = random_term();
      term.func = zph_pkg::FUNC_SIDE;
      term.last = 1'b1;
      drive_term(term);
   endtask

   task automatic drive_noise();
      zph_pkg::item_type term;
      int length;
      length = $urandom_range(1, 6);
      for (int i = 0; i < length; i++) begin
         term      = random_term();
         term.last = (i == length - 1);
         drive_term(term);
      end
   endtask

   initial begin
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      drive_term(make_term(zph_pkg::FUNC_PIECE, 0, 0, 0, 0, 1, 0));
      drive_term(make_term(zph_pkg::FUNC_PIECE, 6, 1, 63, 0, 1, 0));
      drive_term(make_term(zph_pkg::FUNC_PIECE, 7, 1, 10, 0, 1, 0));
      drive_term(make_term(zph_pkg::FUNC_PIECE, 3, 0, 20, 0, 0, 0));
      drive_term(make_term(zph_pkg::FUNC_CASTLE, 0, 0, 0, 0, 0, 0));
      drive_term(make_term(zph_pkg::FUNC_CASTLE, 0, 0, 0, 15, 1, 0));
      drive_term(make_term(zph_pkg::FUNC_EP, 0, 0, 0, 0, 1, 0));
      drive_term(make_term(zph_pkg::FUNC_EP, 0, 0, 63, 0, 1, 0));
      drive_term(make_term(zph_pkg::FUNC_EP, 0, 0, 40, 0, 0, 0));
      drive_term(make_term(zph_pkg::FUNC_SIDE, 0, 0, 0, 0, 1, 0));
      drive_term(make_term(zph_pkg::FUNC_SIDE, 0, 0, 0, 0, 0, 1));
      drive_term(make_term(zph_pkg::FUNC_CASTLE, 0, 0, 0, 5, 0, 1));
      drive_term(make_term(zph_pkg::FUNC_PIECE, 7, 0, 63, 15, 1, 1));
      drive_term(make_term(zph_pkg::FUNC_SIDE, 7, 1, 63, 15, 1, 1));
      drive_term(make_term(zph_pkg::FUNC_EP, 0, 0, 63, 0, 0, 1));
      drive_term(make_term(zph_pkg::FUNC_PIECE, 5, 1, 33, 0, 1, 0));
      drive_term(make_term(zph_pkg::FUNC_PIECE, 5, 1, 33, 0, 1, 1));
      drive_term(make_term(zph_pkg::FUNC_CASTLE, 0, 0, 0, 10, 1, 1));

      terms_sent = 0;
      while (terms_sent < RANDOM_TERMS) begin
         if ($urandom_range(0, 4) == 0)
            drive_noise();
         else
            drive_position();
      end
      req_ch.valid <= 1'b0;

      while (sb.pending() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (sb.mismatches == 0 && sb.pending() == 0)
         $display("Test completed successfully");
      else
         $display("Test completed with failures");
      $finish;
   end

endmodule

/* sim.f */
rtl/zph_pkg.sv
rtl/zph_if.sv
rtl/zph_dp.sv
rtl/zph_ctrl.sv
rtl/zobrist_position_hash_unit.sv
rtl/zph_checker.sv
bench/zobrist_position_hash_unit_tb.sv
